// ===== rtl/bbpm_pkg.sv =====
// ----------------------------------------------------------------------------
// bbpm_pkg
// Shared types, constants and codes for the bounding box pair matcher.
// ----------------------------------------------------------------------------
package bbpm_pkg;

  localparam int MAX_RIGHT_BOXES = 16;
  localparam int COORD_BITS      = 12;
  localparam int OUT_BITS        = 13;
  localparam int THR_BITS        = 12;
  localparam int IDX_BITS        = $clog2(MAX_RIGHT_BOXES);
  localparam int CNT_BITS        = $clog2(MAX_RIGHT_BOXES + 1);
  localparam int KIND_BITS       = 3;
  localparam int FUNC_BITS       = 2;
  localparam int IN_DATA_BITS    = 48;
  localparam int OUT_DATA_BITS   = 56;

  localparam logic [THR_BITS-1:0] THRESHOLD_RESET = THR_BITS'(30);

  typedef enum logic [FUNC_BITS-1:0] {
    FUNC_CLEAR = 2'd0,
    FUNC_STORE = 2'd1,
    FUNC_MATCH = 2'd2
  } func_e;

  typedef enum logic [KIND_BITS-1:0] {
    KIND_TOP_LEFT     = 3'd0,
    KIND_TOP_RIGHT    = 3'd1,
    KIND_BOTTOM_LEFT  = 3'd2,
    KIND_BOTTOM_RIGHT = 3'd3,
    KIND_CENTRE       = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CMP,
    ST_EMIT
  } state_e;

  // x in the lowest bits, as on the input bus
  typedef struct packed {
    logic [COORD_BITS-1:0] h;
    logic [COORD_BITS-1:0] w;
    logic [COORD_BITS-1:0] y;
    logic [COORD_BITS-1:0] x;
  } box_t;

  typedef struct packed {
    logic clear;
    logic store;
    logic cap;
    logic idx_clr;
    logic idx_inc;
    logic rd_en;
    logic take;
    logic kind_clr;
    logic emit_load;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic idx_last;
    logic out_free;
    logic kind_last;
  } sts_t;

endpackage

// ===== rtl/bounding_box_pair_matcher.sv =====
// ----------------------------------------------------------------------------
// bounding_box_pair_matcher
// Stereo box pair matcher: stores right boxes, matches left boxes by size and
// emits five corresponding point pairs per match.
// ----------------------------------------------------------------------------
// A match beat scans the store in order, a registered store read and then a
// compare per entry, until the first hit or the last of 16 entries, then issues
// five output beats at one per cycle while the output side keeps up; the single
// output register sets that pace. A new input beat is taken once the last
// output beat of a match is loaded, or the scan ends without a hit.
module bounding_box_pair_matcher (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // box_x[11:0], box_y[23:12], box_width[35:24], box_height[47:36]
  input  logic [bbpm_pkg::IN_DATA_BITS-1:0]    s_axis_tdata,
  // func[1:0]
  input  logic [bbpm_pkg::FUNC_BITS-1:0]       s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // left_px[12:0], left_py[25:13], right_px[38:26], right_py[51:39], zero
  output logic [bbpm_pkg::OUT_DATA_BITS-1:0]   m_axis_tdata,
  // point_kind[2:0]
  output logic [bbpm_pkg::KIND_BITS-1:0]       m_axis_tuser,
  output logic                                 m_axis_tlast,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [bbpm_pkg::THR_BITS-1:0]        cfg_data_i
);
  import bbpm_pkg::*;

  cmd_t cmd;
  sts_t sts;
  box_t in_box;

  assign in_box      = box_t'(s_axis_tdata);
  assign cfg_ready_o = 1'b1;

  bbpm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_func_i  (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bbpm_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_box_i    (in_box),
    .cfg_we_i    (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata),
    .out_kind_o  (m_axis_tuser),
    .out_last_o  (m_axis_tlast)
  );

endmodule

// ===== rtl/bbpm_ctrl.sv =====
// ----------------------------------------------------------------------------
// bbpm_ctrl
// Sequencer: accepts a beat, steps the store scan and the five output beats.
// ----------------------------------------------------------------------------
module bbpm_ctrl (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  input  logic [bbpm_pkg::FUNC_BITS-1:0]   in_func_i,
  output logic                             in_ready_o,
  input  bbpm_pkg::sts_t                   sts_i,
  output bbpm_pkg::cmd_t                   cmd_o
);
  import bbpm_pkg::*;

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && in_func_i == FUNC_MATCH) begin
          state_d = ST_READ;
        end
      end
      ST_READ: state_d = ST_CMP;
      ST_CMP: begin
        priority if (sts_i.hit) begin
          state_d = ST_EMIT;
        end else if (sts_i.idx_last) begin
          state_d = ST_IDLE;
        end else begin
          state_d = ST_READ;
        end
      end
      ST_EMIT: begin
        if (sts_i.out_free && sts_i.kind_last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.cap     = accept;
        cmd_o.idx_clr = accept;
        cmd_o.clear   = accept && in_func_i == FUNC_CLEAR;
        cmd_o.store   = accept && in_func_i == FUNC_STORE;
      end
      ST_READ: cmd_o.rd_en = 1'b1;
      ST_CMP: begin
        cmd_o.take     = sts_i.hit;
        cmd_o.kind_clr = sts_i.hit;
        cmd_o.idx_inc  = !sts_i.hit && !sts_i.idx_last;
      end
      ST_EMIT: cmd_o.emit_load = sts_i.out_free;
      default: cmd_o = '0;
    endcase
  end

endmodule

// ===== rtl/bbpm_datapath.sv =====
// ----------------------------------------------------------------------------
// bbpm_datapath
// Right box store, valid bits, fill count, scan compare and point output.
// ----------------------------------------------------------------------------
module bbpm_datapath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  bbpm_pkg::box_t                       in_box_i,
  input  logic                                 cfg_we_i,
  input  logic [bbpm_pkg::THR_BITS-1:0]        cfg_data_i,
  input  bbpm_pkg::cmd_t                       cmd_i,
  output bbpm_pkg::sts_t                       sts_o,
  input  logic                                 out_ready_i,
  output logic                                 out_valid_o,
  output logic [bbpm_pkg::OUT_DATA_BITS-1:0]   out_data_o,
  output logic [bbpm_pkg::KIND_BITS-1:0]       out_kind_o,
  output logic                                 out_last_o
);
  import bbpm_pkg::*;

  box_t                      mem [MAX_RIGHT_BOXES];
  box_t                      rd_q;
  box_t                      left_q;
  logic [MAX_RIGHT_BOXES-1:0] valid_q;
  logic [CNT_BITS-1:0]       fill_q;
  logic [IDX_BITS-1:0]       idx_q;
  logic [KIND_BITS-1:0]      kind_q;
  logic [THR_BITS-1:0]       thr_q;
  logic                      ovalid_q;
  logic [OUT_DATA_BITS-1:0]  odata_q;
  logic [KIND_BITS-1:0]      okind_q;
  logic                      olast_q;

  logic                      can_store;
  logic [COORD_BITS-1:0]     dw, dh;
  logic [OUT_BITS-1:0]       lx, ly, rx, ry;
  logic [COORD_BITS:0]       lx2, ly2, rx2, ry2, lxc, lyc, rxc, ryc;

  assign can_store = (fill_q < CNT_BITS'(MAX_RIGHT_BOXES));

  always_ff @(posedge clk_i) begin
    if (cmd_i.store && can_store) begin
      mem[fill_q[IDX_BITS-1:0]] <= in_box_i;
    end
    if (cmd_i.rd_en) begin
      rd_q <= mem[idx_q];
    end
    if (cmd_i.cap) begin
      left_q <= in_box_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      fill_q  <= '0;
      idx_q   <= '0;
      kind_q  <= '0;
      thr_q   <= THRESHOLD_RESET;
    end else begin
      if (cfg_we_i) begin
        thr_q <= cfg_data_i;
      end
      priority if (cmd_i.clear) begin
        valid_q <= '0;
        fill_q  <= '0;
      end else if (cmd_i.store && can_store) begin
        valid_q[fill_q[IDX_BITS-1:0]] <= 1'b1;
        fill_q <= fill_q + CNT_BITS'(1);
      end else if (cmd_i.take) begin
        valid_q[idx_q] <= 1'b0;
      end
      priority if (cmd_i.idx_clr) begin
        idx_q <= '0;
      end else if (cmd_i.idx_inc) begin
        idx_q <= idx_q + IDX_BITS'(1);
      end
      priority if (cmd_i.kind_clr) begin
        kind_q <= '0;
      end else if (cmd_i.emit_load) begin
        kind_q <= kind_q + KIND_BITS'(1);
      end
    end
  end

  assign dw = (left_q.w > rd_q.w) ? left_q.w - rd_q.w : rd_q.w - left_q.w;
  assign dh = (left_q.h > rd_q.h) ? left_q.h - rd_q.h : rd_q.h - left_q.h;

  assign sts_o.hit       = valid_q[idx_q] && (dw < thr_q) && (dh < thr_q);
  assign sts_o.idx_last  = (idx_q == IDX_BITS'(MAX_RIGHT_BOXES - 1));
  assign sts_o.out_free  = !ovalid_q || out_ready_i;
  assign sts_o.kind_last = (kind_q == KIND_CENTRE);

  assign lx2 = {1'b0, left_q.x} + {1'b0, left_q.w};
  assign ly2 = {1'b0, left_q.y} + {1'b0, left_q.h};
  assign rx2 = {1'b0, rd_q.x} + {1'b0, rd_q.w};
  assign ry2 = {1'b0, rd_q.y} + {1'b0, rd_q.h};
  assign lxc = {1'b0, left_q.x} + {2'b0, left_q.w[COORD_BITS-1:1]};
  assign lyc = {1'b0, left_q.y} + {2'b0, left_q.h[COORD_BITS-1:1]};
  assign rxc = {1'b0, rd_q.x} + {2'b0, rd_q.w[COORD_BITS-1:1]};
  assign ryc = {1'b0, rd_q.y} + {2'b0, rd_q.h[COORD_BITS-1:1]};

  always_comb begin
    lx = OUT_BITS'(left_q.x);
    ly = OUT_BITS'(left_q.y);
    rx = OUT_BITS'(rd_q.x);
    ry = OUT_BITS'(rd_q.y);
    unique case (kind_q)
      KIND_TOP_LEFT: ;
      KIND_TOP_RIGHT: begin
        lx = OUT_BITS'(lx2);
        rx = OUT_BITS'(rx2);
      end
      KIND_BOTTOM_LEFT: begin
        ly = OUT_BITS'(ly2);
        ry = OUT_BITS'(ry2);
      end
      KIND_BOTTOM_RIGHT: begin
        lx = OUT_BITS'(lx2);
        ly = OUT_BITS'(ly2);
        rx = OUT_BITS'(rx2);
        ry = OUT_BITS'(ry2);
      end
      KIND_CENTRE: begin
        lx = OUT_BITS'(lxc);
        ly = OUT_BITS'(lyc);
        rx = OUT_BITS'(rxc);
        ry = OUT_BITS'(ryc);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (cmd_i.emit_load) begin
      ovalid_q <= 1'b1;
    end else if (out_ready_i) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_load) begin
      odata_q <= {(OUT_DATA_BITS - 4 * OUT_BITS)'(0), ry, rx, ly, lx};
      okind_q <= kind_q;
      olast_q <= (kind_q == KIND_CENTRE);
    end
  end

  assign out_valid_o = ovalid_q;
  assign out_data_o  = odata_q;
  assign out_kind_o  = okind_q;
  assign out_last_o  = olast_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CNT_BITS'(MAX_RIGHT_BOXES))
    else $error("fill count beyond store depth");

  a_valid_le_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) <= int'(fill_q))
    else $error("more valid entries than stored boxes");

  a_take_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.take |=> !valid_q[$past(idx_q)])
    else $error("matched entry still valid");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_load |-> (!ovalid_q || out_ready_i))
    else $error("output beat overwritten before taken");

endmodule

// ===== tb/bounding_box_pair_matcher_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounding_box_pair_matcher_tb
// Self-checking bench for the stereo box pair matcher. A table of directed
// beats covers empty and full stores, exact size limits, coordinate extremes
// and the unused function code. Random store/match frames follow under
// several thresholds. A local predictor tracks the right-box store and
// checks every output point pair in order. Both stream sides idle at random;
// the output side also holds off for a long stretch.
// ----------------------------------------------------------------------------
module bounding_box_pair_matcher_tb;
  import bbpm_pkg::*;

  localparam logic [FUNC_BITS-1:0] FUNC_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SCAN_CYCLES = 2 * MAX_RIGHT_BOXES + 8;
  localparam int HOLD_CYCLES = 300;
  localparam int SIZE_STEP   = 40;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [KIND_BITS-1:0] kind;
    logic [OUT_BITS-1:0]  lx;
    logic [OUT_BITS-1:0]  ly;
    logic [OUT_BITS-1:0]  rx;
    logic [OUT_BITS-1:0]  ry;
    logic                 last;
  } point_t;

  typedef struct packed {
    logic [FUNC_BITS-1:0] func;
    box_t                 b;
    logic [7:0]           reps;
    logic                 typed;
    logic [2:0]           n_typed;
  } stim_row_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     s_axis_tvalid = 1'b0;
  logic                     s_axis_tready;
  // box_x[11:0], box_y[23:12], box_width[35:24], box_height[47:36]
  logic [IN_DATA_BITS-1:0]  s_axis_tdata = '0;
  // func[1:0]
  logic [FUNC_BITS-1:0]     s_axis_tuser = '0;
  logic                     m_axis_tvalid;
  logic                     m_axis_tready = 1'b0;
  // left_px[12:0], left_py[25:13], right_px[38:26], right_py[51:39], zero
  logic [OUT_DATA_BITS-1:0] m_axis_tdata;
  // point_kind[2:0]
  logic [KIND_BITS-1:0]     m_axis_tuser;
  logic                     m_axis_tlast;
  logic                     cfg_valid_i = 1'b0;
  logic                     cfg_ready_o;
  logic [THR_BITS-1:0]      cfg_data_i = '0;

  bounding_box_pair_matcher DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  // predicted store state
  box_t                       right_boxes [MAX_RIGHT_BOXES];
  logic [MAX_RIGHT_BOXES-1:0] slot_live = '0;
  int                         fill_level = 0;
  logic [THR_BITS-1:0]        size_thr = THRESHOLD_RESET;

  point_t    fresh_pts [$];
  point_t    expected_points [$];
  point_t    typed_pts [$];
  stim_row_t stim_rows [$];

  int idle_pct = 27;
  int holds_asked = 0;
  int holds_done = 0;
  int hold_left = 0;
  int cycle_count = 0;
  int mismatches = 0;
  int leftovers = 0;
  int points_checked = 0;
  int pairs_matched = 0;
  int dropped_boxes = 0;
  int thr_writes = 0;
  int beats_by_func [4] = '{0, 0, 0, 0};

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d points still due", cycle_count,
               expected_points.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic point_t mk_point(input logic [KIND_BITS-1:0] k,
                                      input logic [OUT_BITS-1:0] lx,
                                      input logic [OUT_BITS-1:0] ly,
                                      input logic [OUT_BITS-1:0] rx,
                                      input logic [OUT_BITS-1:0] ry);
    point_t p;
    p.kind = k;
    p.lx   = lx;
    p.ly   = ly;
    p.rx   = rx;
    p.ry   = ry;
    p.last = (k == KIND_CENTRE);
    return p;
  endfunction

  function automatic void predict_beat(input logic [FUNC_BITS-1:0] f, input box_t b);
    int   hit;
    int   dw;
    int   dh;
    box_t r;
    logic [OUT_BITS-1:0] lx, ly, lx2, ly2, lcx, lcy;
    logic [OUT_BITS-1:0] rx, ry, rx2, ry2, rcx, rcy;
    hit = -1;
    fresh_pts.delete();
    case (f)
      FUNC_CLEAR: begin
        slot_live  = '0;
        fill_level = 0;
      end
      FUNC_STORE: begin
        if (fill_level < MAX_RIGHT_BOXES) begin
          right_boxes[fill_level] = b;
          slot_live[fill_level]   = 1'b1;
          fill_level++;
        end else begin
          dropped_boxes++;
        end
      end
      FUNC_MATCH: begin
        for (int i = 0; i < MAX_RIGHT_BOXES; i++) begin
          if (hit < 0 && slot_live[i]) begin
            dw = int'(b.w) - int'(right_boxes[i].w);
            dh = int'(b.h) - int'(right_boxes[i].h);
            if (dw < 0) dw = -dw;
            if (dh < 0) dh = -dh;
            if (dw < int'(size_thr) && dh < int'(size_thr)) hit = i;
          end
        end
        if (hit >= 0) begin
          slot_live[hit] = 1'b0;
          r   = right_boxes[hit];
          lx  = OUT_BITS'(b.x);
          ly  = OUT_BITS'(b.y);
          lx2 = OUT_BITS'(b.x) + OUT_BITS'(b.w);
          ly2 = OUT_BITS'(b.y) + OUT_BITS'(b.h);
          lcx = OUT_BITS'(b.x) + OUT_BITS'(b.w >> 1);
          lcy = OUT_BITS'(b.y) + OUT_BITS'(b.h >> 1);
          rx  = OUT_BITS'(r.x);
          ry  = OUT_BITS'(r.y);
          rx2 = OUT_BITS'(r.x) + OUT_BITS'(r.w);
          ry2 = OUT_BITS'(r.y) + OUT_BITS'(r.h);
          rcx = OUT_BITS'(r.x) + OUT_BITS'(r.w >> 1);
          rcy = OUT_BITS'(r.y) + OUT_BITS'(r.h >> 1);
          fresh_pts = {fresh_pts, mk_point(KIND_TOP_LEFT, lx, ly, rx, ry)};
          fresh_pts = {fresh_pts, mk_point(KIND_TOP_RIGHT, lx2, ly, rx2, ry)};
          fresh_pts = {fresh_pts, mk_point(KIND_BOTTOM_LEFT, lx, ly2, rx, ry2)};
          fresh_pts = {fresh_pts, mk_point(KIND_BOTTOM_RIGHT, lx2, ly2, rx2, ry2)};
          fresh_pts = {fresh_pts, mk_point(KIND_CENTRE, lcx, lcy, rcx, rcy)};
        end
      end
      default: ;
    endcase
  endfunction

  function automatic box_t mk_box(input int x, input int y, input int w, input int h);
    box_t b;
    b.x = COORD_BITS'(x);
    b.y = COORD_BITS'(y);
    b.w = COORD_BITS'(w);
    b.h = COORD_BITS'(h);
    return b;
  endfunction

  function automatic void add_row(input logic [FUNC_BITS-1:0] f, input int x, input int y,
                                  input int w, input int h, input int reps,
                                  input logic typed, input int n_typed);
    stim_row_t row;
    row.func    = f;
    row.b       = mk_box(x, y, w, h);
    row.reps    = 8'(reps);
    row.typed   = typed;
    row.n_typed = 3'(n_typed);
    stim_rows   = {stim_rows, row};
  endfunction

  function automatic void add_typed(input logic [KIND_BITS-1:0] k, input int lx, input int ly,
                                    input int rx, input int ry);
    typed_pts = {typed_pts, mk_point(k, OUT_BITS'(lx), OUT_BITS'(ly), OUT_BITS'(rx),
                                     OUT_BITS'(ry))};
  endfunction

  function automatic void load_stim_table();
    add_row(FUNC_MATCH,  100,  200,   50,   60,  1, 1'b1, 0);
    add_row(FUNC_UNUSED, 4095, 4095, 4095, 4095, 1, 1'b1, 0);
    add_row(FUNC_STORE,  0,    0,    0,    0,    1, 1'b1, 0);
    add_row(FUNC_MATCH,  0,    0,    0,    0,    1, 1'b1, 5);
    add_row(FUNC_STORE,  4095, 4095, 4095, 4095, 1, 1'b1, 0);
    add_row(FUNC_MATCH,  4095, 4095, 4095, 4095, 1, 1'b1, 5);
    add_row(FUNC_STORE,  10,   20,   100,  50,   1, 1'b1, 0);
    add_row(FUNC_MATCH,  300,  400,  130,  50,   1, 1'b1, 0);
    add_row(FUNC_MATCH,  300,  400,  100,  80,   1, 1'b1, 0);
    add_row(FUNC_MATCH,  5,    6,    71,   21,   1, 1'b0, 0);
    add_row(FUNC_CLEAR,  0,    0,    0,    0,    1, 1'b1, 0);
    // fill the store, the last box is dropped
    add_row(FUNC_STORE,  1000, 2000, 100,  300, MAX_RIGHT_BOXES + 1, 1'b1, 0);
    add_row(FUNC_MATCH,  7,    9,    740,  300,  1, 1'b1, 0);
    add_row(FUNC_MATCH,  3000, 3000, 700,  310,  1, 1'b0, 0);
    add_row(FUNC_MATCH,  50,   60,   95,   295,  1, 1'b0, 0);
    add_row(FUNC_CLEAR,  0,    0,    0,    0,    1, 1'b1, 0);
    add_row(FUNC_STORE,  4095, 0,    0,    4095, 1, 1'b1, 0);
    add_row(FUNC_MATCH,  0,    4095, 29,   4066, 1, 1'b0, 0);

    add_typed(KIND_TOP_LEFT,     0, 0, 0, 0);
    add_typed(KIND_TOP_RIGHT,    0, 0, 0, 0);
    add_typed(KIND_BOTTOM_LEFT,  0, 0, 0, 0);
    add_typed(KIND_BOTTOM_RIGHT, 0, 0, 0, 0);
    add_typed(KIND_CENTRE,       0, 0, 0, 0);
    add_typed(KIND_TOP_LEFT,     4095, 4095, 4095, 4095);
    add_typed(KIND_TOP_RIGHT,    8190, 4095, 8190, 4095);
    add_typed(KIND_BOTTOM_LEFT,  4095, 8190, 4095, 8190);
    add_typed(KIND_BOTTOM_RIGHT, 8190, 8190, 8190, 8190);
    add_typed(KIND_CENTRE,       6142, 6142, 6142, 6142);
  endfunction

  task automatic send_beat(input logic [FUNC_BITS-1:0] f, input box_t b,
                           input logic typed, input int n_typed);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= f;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    beats_by_func[f]++;
    predict_beat(f, b);
    if (fresh_pts.size() != 0) pairs_matched++;
    if (typed) begin
      repeat (n_typed) expected_points = {expected_points, typed_pts.pop_front()};
    end else begin
      expected_points = {expected_points, fresh_pts};
    end
  endtask

  task automatic drain_outputs();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk_i);
    repeat (SCAN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_threshold(input logic [THR_BITS-1:0] thr);
    drain_outputs();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= thr;
    do @(posedge clk_i); while (!cfg_ready_o);
    size_thr = thr;
    thr_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic int rand_coord();
    int sel;
    sel = $urandom_range(9);
    if (sel == 0) return 0;
    if (sel == 1) return (1 << COORD_BITS) - 1;
    return $urandom_range((1 << COORD_BITS) - 1);
  endfunction

  function automatic box_t rand_box();
    return mk_box(rand_coord(), rand_coord(), rand_coord(), rand_coord());
  endfunction

  function automatic logic [COORD_BITS-1:0] near_size(input logic [COORD_BITS-1:0] s);
    int span;
    int v;
    span = (size_thr < 100) ? int'(size_thr) + 1 : 100;
    v = int'(s) + int'($urandom_range(2 * span)) - span;
    if (v < 0) v = 0;
    if (v > (1 << COORD_BITS) - 1) v = (1 << COORD_BITS) - 1;
    return COORD_BITS'(v);
  endfunction

  // one store/match frame, or a few beats of noise
  task automatic random_frame(inout int budget);
    int   n_store;
    int   n_match;
    int   slot;
    box_t b;
    logic [FUNC_BITS-1:0] f;
    if ($urandom_range(99) < 75) begin
      if ($urandom_range(1) == 0) begin
        send_beat(FUNC_CLEAR, rand_box(), 1'b0, 0);
        budget--;
      end
      n_store = ($urandom_range(9) == 0) ? $urandom_range(14, 20) : $urandom_range(1, 6);
      repeat (n_store) begin
        send_beat(FUNC_STORE, rand_box(), 1'b0, 0);
        budget--;
      end
      n_match = $urandom_range(1, n_store + 1);
      repeat (n_match) begin
        b = rand_box();
        if (fill_level > 0 && $urandom_range(99) < 80) begin
          slot = $urandom_range(fill_level - 1);
          b.w  = near_size(right_boxes[slot].w);
          b.h  = near_size(right_boxes[slot].h);
        end
        send_beat(FUNC_MATCH, b, 1'b0, 0);
        budget--;
      end
    end else begin
      repeat ($urandom_range(1, 3)) begin
        f = FUNC_BITS'($urandom_range(3));
        send_beat(f, rand_box(), 1'b0, 0);
        if (f != FUNC_UNUSED) budget--;
      end
    end
  endtask

  initial begin
    forever begin
      @(negedge clk_i);
      if (holds_asked != holds_done) begin
        holds_done++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    point_t got;
    point_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.kind = m_axis_tuser;
      got.lx   = m_axis_tdata[12:0];
      got.ly   = m_axis_tdata[25:13];
      got.rx   = m_axis_tdata[38:26];
      got.ry   = m_axis_tdata[51:39];
      got.last = m_axis_tlast;
      points_checked++;
      if (expected_points.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected point kind=%0d L(%0d,%0d) R(%0d,%0d) last=%0b",
                   $realtime, got.kind, got.lx, got.ly, got.rx, got.ry, got.last);
      end else begin
        want = expected_points.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display({"%0t: point mismatch, expected kind=%0d L(%0d,%0d) R(%0d,%0d) ",
                      "last=%0b, got kind=%0d L(%0d,%0d) R(%0d,%0d) last=%0b"},
                     $realtime, want.kind, want.lx, want.ly, want.rx, want.ry, want.last,
                     got.kind, got.lx, got.ly, got.rx, got.ry, got.last);
        end
      end
    end
  end

  initial begin
    box_t                b;
    int                  budget;
    logic [THR_BITS-1:0] thr;
    load_stim_table();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (stim_rows[i]) begin
      for (int k = 0; k < int'(stim_rows[i].reps); k++) begin
        b   = stim_rows[i].b;
        b.w = b.w + COORD_BITS'(SIZE_STEP * k);
        send_beat(stim_rows[i].func, b, stim_rows[i].typed, int'(stim_rows[i].n_typed));
      end
    end

    for (int p = 0; p < 6; p++) begin
      case (p)
        0:       thr = '0;
        1:       thr = '1;
        2:       thr = THR_BITS'(1);
        3:       thr = THR_BITS'($urandom_range(2, 200));
        4:       thr = THR_BITS'($urandom_range(201, 4094));
        default: thr = THRESHOLD_RESET;
      endcase
      write_threshold(thr);
      if (p == 2) idle_pct = 0;
      if (p == 3) holds_asked++;
      budget = 7;
      while (budget > 0) random_frame(budget);
      idle_pct = 27;
    end

    drain_outputs();
    leftovers = expected_points.size();
    $display({"Ran %0d beats: %0d clear, %0d store (%0d dropped on a full store), ",
              "%0d match, %0d unused"},
             beats_by_func[0] + beats_by_func[1] + beats_by_func[2] + beats_by_func[3],
             beats_by_func[0], beats_by_func[1], dropped_boxes, beats_by_func[2],
             beats_by_func[3]);
    $display("%0d pairs matched, %0d points checked over %0d threshold settings, %0d mismatches",
             pairs_matched, points_checked, thr_writes + 1, mismatches);
    if (mismatches == 0 && leftovers == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
